// ----- hdl/ips_pkg.sv -----
// ----------------------------------------------------------------------------
// ips_pkg
// Shared constants, beat types, controller state and command/status bundles
// for the interval probe statistics block.
// ----------------------------------------------------------------------------
package ips_pkg;

	// Bank geometry
	localparam int NUM_PROBES = 16;
	localparam int WINDOW     = 100;

	localparam int PROBE_W    = 4;
	localparam int TS_W       = 32;
	localparam int FR_W       = 32;
	localparam int SUM_W      = 39;
	localparam int PIDX_W     = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
	localparam int POS_W      = $clog2(WINDOW);
	localparam int CNT_W      = $clog2(WINDOW + 2);
	localparam int RING_DEPTH = NUM_PROBES * WINDOW;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	// Register file
	localparam int          PADDR_W         = 3;
	localparam int          PDATA_W         = 32;
	localparam logic [0:0]  REG_FRAME_SCALE = 1'b0;
	localparam logic [31:0] SCALE_RESET     = 32'd416583382;

	// Item function codes
	localparam logic [0:0] FUNC_START = 1'b0;
	localparam logic [0:0] FUNC_STOP  = 1'b1;

	// Average: (24 * old + new + 12) / 25
	localparam int NUM_W      = 37;
	localparam int AVG_SHIFT  = NUM_W - FR_W;
	localparam int AVG_OLD_W  = 24;
	localparam int AVG_DIV    = 25;
	localparam int AVG_RND    = 12;
	localparam int QEST_W     = 33;
	localparam int REM_W      = 7;
	// floor(2^36 / 25); estimate = (num >> 5) * recip >> 31, at most 3 short
	localparam logic [31:0] AVG_RECIP = 32'((64'd1 << (31 + AVG_SHIFT)) / 64'd25);

	typedef struct packed {
		logic [0:0]         func;
		logic [PROBE_W-1:0] probe;
		logic [TS_W-1:0]    timestamp;
	} item_t;

	typedef struct packed {
		logic [FR_W-1:0]  last_frames;
		logic [FR_W-1:0]  average_frames;
		logic [SUM_W-1:0] window_sum;
		logic [FR_W-1:0]  peak_frames;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_DMUL,
		S_DCORR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic stamp_we;
		logic mul;
		logic acc;
		logic dmul;
		logic dcorr;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/ips_ctrl.sv -----
// ----------------------------------------------------------------------------
// ips_ctrl
// Sequencer for one probe event: accept, scale, accumulate, divide, commit.
// ----------------------------------------------------------------------------
module ips_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  ips_pkg::item_t item,
	input  ips_pkg::sts_t  sts,
	output logic           item_stall,
	output ips_pkg::cmd_t  cmd
);

	ips_pkg::state_t state_q;
	ips_pkg::state_t state_nxt;
	logic            probe_ok;

	assign probe_ok = (int'(item.probe) < ips_pkg::NUM_PROBES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ips_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ips_pkg::S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && probe_ok) begin
					if (item.func == ips_pkg::FUNC_STOP) begin
						cmd.capture = 1'b1;
						state_nxt   = ips_pkg::S_MUL;
					end else begin
						cmd.stamp_we = 1'b1;
					end
				end
			end
			ips_pkg::S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ips_pkg::S_ACC;
			end
			ips_pkg::S_ACC: begin
				cmd.acc   = 1'b1;
				state_nxt = ips_pkg::S_DMUL;
			end
			ips_pkg::S_DMUL: begin
				cmd.dmul  = 1'b1;
				state_nxt = ips_pkg::S_DCORR;
			end
			ips_pkg::S_DCORR: begin
				cmd.dcorr = 1'b1;
				state_nxt = ips_pkg::S_DONE;
			end
			ips_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ips_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = ips_pkg::S_IDLE;
			end
		endcase
	end

	// result register must be free whenever a result is committed
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while output register busy");

	// a captured stop always moves straight into the scale step
	a_capture_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.mul)
		else $error("capture not followed by scale step");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.stamp_we, cmd.mul, cmd.acc, cmd.dmul,
			cmd.dcorr, cmd.commit}))
		else $error("more than one datapath command");

endmodule

// ----- hdl/ips_datapath.sv -----
// ----------------------------------------------------------------------------
// ips_datapath
// Per-probe stores, history ring memory, scaling and average arithmetic,
// and the result register.
// ----------------------------------------------------------------------------
module ips_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ips_pkg::cmd_t                  cmd,
	input  ips_pkg::item_t                 item,
	input  logic [ips_pkg::FR_W-1:0]       frame_scale,
	input  logic                           result_stall,
	output ips_pkg::sts_t                  sts,
	output logic                           result_valid,
	output ips_pkg::result_t               result
);

	// per-probe state, cleared at reset
	logic [ips_pkg::TS_W-1:0]  stamp_q [ips_pkg::NUM_PROBES];
	logic [ips_pkg::FR_W-1:0]  avg_q   [ips_pkg::NUM_PROBES];
	logic [ips_pkg::FR_W-1:0]  peak_q  [ips_pkg::NUM_PROBES];
	logic [ips_pkg::SUM_W-1:0] sum_q   [ips_pkg::NUM_PROBES];
	logic [ips_pkg::POS_W-1:0] pos_q   [ips_pkg::NUM_PROBES];
	logic [ips_pkg::CNT_W-1:0] cnt_q   [ips_pkg::NUM_PROBES];

	// history ring; a slot's read value is only used once the probe has filled its window
	logic [ips_pkg::FR_W-1:0]  ring_mem [ips_pkg::RING_DEPTH];

	logic [ips_pkg::PROBE_W-1:0] probe_q;
	logic [ips_pkg::TS_W-1:0]    ts_q;
	logic [ips_pkg::RING_AW-1:0] ring_addr_s1;
	logic [ips_pkg::FR_W-1:0]    ring_rd_s1;
	logic [63:0]                 prod_s1;
	logic [ips_pkg::FR_W-1:0]    last_s2;
	logic [ips_pkg::NUM_W-1:0]   num_s2;
	logic [ips_pkg::SUM_W-1:0]   sum_s2;
	logic [ips_pkg::FR_W-1:0]    peak_s2;
	logic [63:0]                 dprod_s3;
	logic [ips_pkg::QEST_W-1:0]  q_s4;
	logic [ips_pkg::REM_W-1:0]   rem_s4;
	logic                        out_valid_q;
	ips_pkg::result_t            out_q;

	logic [ips_pkg::PIDX_W-1:0]  idx_in;
	logic [ips_pkg::PIDX_W-1:0]  idx;
	logic [ips_pkg::TS_W-1:0]    diff;
	logic [ips_pkg::RING_AW-1:0] ring_rd_addr;
	logic [ips_pkg::FR_W-1:0]    last;
	logic [ips_pkg::FR_W-1:0]    old_val;
	logic [ips_pkg::SUM_W-1:0]   sum_next;
	logic [ips_pkg::NUM_W-1:0]   num_next;
	logic                        peak_upd;
	logic [ips_pkg::QEST_W-1:0]  q_est;
	logic [ips_pkg::NUM_W-1:0]   rem_full;
	logic [1:0]                  corr;
	logic [ips_pkg::FR_W-1:0]    avg_new;
	logic [ips_pkg::POS_W-1:0]   pos_next;
	logic [ips_pkg::CNT_W-1:0]   cnt_next;

	assign idx_in = ips_pkg::PIDX_W'(item.probe);
	assign idx    = ips_pkg::PIDX_W'(probe_q);

	// scale step
	assign diff         = ts_q - stamp_q[idx];
	assign ring_rd_addr = ips_pkg::RING_AW'(idx) * ips_pkg::RING_AW'(ips_pkg::WINDOW)
		+ ips_pkg::RING_AW'(pos_q[idx]);

	// accumulate step
	assign last     = prod_s1[63:32];
	assign old_val  = (cnt_q[idx] >= ips_pkg::CNT_W'(ips_pkg::WINDOW)) ? ring_rd_s1 : '0;
	assign sum_next = sum_q[idx] - ips_pkg::SUM_W'(old_val) + ips_pkg::SUM_W'(last);
	assign num_next = ips_pkg::NUM_W'(avg_q[idx]) * ips_pkg::NUM_W'(ips_pkg::AVG_OLD_W)
		+ ips_pkg::NUM_W'(last) + ips_pkg::NUM_W'(ips_pkg::AVG_RND);
	assign peak_upd = (peak_q[idx] < last)
		&& (cnt_q[idx] > ips_pkg::CNT_W'(ips_pkg::WINDOW));

	// divide by 25: reciprocal estimate, remainder, then a small fixup
	assign q_est    = dprod_s3[63:31];
	assign rem_full = num_s2 - ips_pkg::NUM_W'(q_est) * ips_pkg::NUM_W'(ips_pkg::AVG_DIV);

	always_comb begin
		if (rem_s4 >= ips_pkg::REM_W'(3 * ips_pkg::AVG_DIV)) begin
			corr = 2'd3;
		end else if (rem_s4 >= ips_pkg::REM_W'(2 * ips_pkg::AVG_DIV)) begin
			corr = 2'd2;
		end else if (rem_s4 >= ips_pkg::REM_W'(ips_pkg::AVG_DIV)) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
	end

	assign avg_new  = ips_pkg::FR_W'(q_s4 + ips_pkg::QEST_W'(corr));
	assign pos_next = (pos_q[idx] == ips_pkg::POS_W'(ips_pkg::WINDOW - 1))
		? '0 : pos_q[idx] + 1'b1;
	assign cnt_next = (cnt_q[idx] < ips_pkg::CNT_W'(ips_pkg::WINDOW + 1))
		? cnt_q[idx] + 1'b1 : cnt_q[idx];

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			probe_q <= item.probe;
			ts_q    <= item.timestamp;
		end
		if (cmd.mul) begin
			prod_s1      <= 64'(diff) * 64'(frame_scale);
			ring_addr_s1 <= ring_rd_addr;
		end
		if (cmd.acc) begin
			last_s2 <= last;
			num_s2  <= num_next;
			sum_s2  <= sum_next;
			peak_s2 <= peak_upd ? last : peak_q[idx];
		end
		if (cmd.dmul) begin
			dprod_s3 <= 64'(num_s2[ips_pkg::NUM_W-1:ips_pkg::AVG_SHIFT]) * 64'(ips_pkg::AVG_RECIP);
		end
		if (cmd.dcorr) begin
			q_s4   <= q_est;
			rem_s4 <= ips_pkg::REM_W'(rem_full);
		end
		if (cmd.commit) begin
			out_q.last_frames    <= last_s2;
			out_q.average_frames <= avg_new;
			out_q.window_sum     <= sum_s2;
			out_q.peak_frames    <= peak_s2;
		end
	end

	// ring memory: read in the scale step, written in the accumulate step
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			ring_rd_s1 <= ring_mem[ring_rd_addr];
		end
		if (cmd.acc) begin
			ring_mem[ring_addr_s1] <= last;
		end
	end

	// per-probe stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ips_pkg::NUM_PROBES; i++) begin
				stamp_q[i] <= '0;
				avg_q[i]   <= '0;
				peak_q[i]  <= '0;
				sum_q[i]   <= '0;
				pos_q[i]   <= '0;
				cnt_q[i]   <= '0;
			end
		end else begin
			if (cmd.stamp_we) begin
				stamp_q[idx_in] <= item.timestamp;
			end
			if (cmd.commit) begin
				avg_q[idx]  <= avg_new;
				peak_q[idx] <= peak_s2;
				sum_q[idx]  <= sum_s2;
				pos_q[idx]  <= pos_next;
				cnt_q[idx]  <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> cnt_q[idx] <= ips_pkg::CNT_W'(ips_pkg::WINDOW + 1))
		else $error("stop count past saturation");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.dcorr) |-> rem_s4 < ips_pkg::REM_W'(4 * ips_pkg::AVG_DIV))
		else $error("average estimate off by more than three");

endmodule

// ----- hdl/interval_probe_statistics.sv -----
// ----------------------------------------------------------------------------
// interval_probe_statistics
// Bank of profiling probes: start/stop timestamp beats give per-probe interval
// in frames (Q16.16), a rounded exponential average, a sum over the last
// window of intervals and a peak once the window has been passed.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                  payload
//  item      in    item_valid / item_stall    ips_pkg::item_t   (func, probe, ts)
//  result    out   result_valid / result_stall ips_pkg::result_t (4 statistics)
//  config    in    APB psel/penable/pready    frame_scale at byte address 0
//
// A start beat is accepted without leaving IDLE; the stamp is written at
// the accept edge. A stop beat runs from accept through MUL for the 32x32
// scale multiply, ACC for the sum/average numerator, DMUL and DCORR for the
// reciprocal divide by 25 and DONE to commit. Items are one at a time.
// A stalled result only holds the commit step; the next item is stalled while DONE waits.
// Reset clears all per-probe stores at once; the history ring needs no
// clearing pass because a slot is used only after its probe filled the window.
// Beats for probes outside the bank are taken and dropped.
//
module interval_probe_statistics (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  ips_pkg::item_t                 item,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output ips_pkg::result_t               result,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ips_pkg::PADDR_W-1:0]    paddr,
	input  logic [ips_pkg::PDATA_W-1:0]    pwdata,
	output logic [ips_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	ips_pkg::cmd_t            cmd;
	ips_pkg::sts_t            sts;
	logic [ips_pkg::FR_W-1:0] frame_scale_q;
	logic                     reg_sel;

	// word-aligned decode; byte lanes below bit 2 are ignored
	assign reg_sel = (paddr[ips_pkg::PADDR_W-1:2] == ips_pkg::REG_FRAME_SCALE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? frame_scale_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_scale_q <= ips_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			frame_scale_q <= pwdata;
		end
	end

	ips_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	ips_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.frame_scale  (frame_scale_q),
		.result_stall (result_stall),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
